>>> rtl/core/ffrp_pkg.sv
// Shared types and constants for the first-fit rectangle packer.
// No dependencies.
package ffrp_pkg;
  localparam int MaxEntries = 64;
  localparam int CoordBits  = 12;
  localparam int ExtBits    = CoordBits + 1;
  localparam int IdxBits    = $clog2(MaxEntries);
  localparam int CntBits    = $clog2(MaxEntries + 1);
  localparam int TagBits    = 16;
  localparam int EntBits    = 2 * CoordBits + 2 * ExtBits + TagBits;

  localparam logic [2:0] StPlaced   = 3'd0;
  localparam logic [2:0] StNoRoom   = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StRemoved  = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;

  localparam logic       OpPack   = 1'b0;
  localparam logic       OpRemove = 1'b1;
  localparam logic       CfgWidth  = 1'b0;
  localparam logic       CfgHeight = 1'b1;

  typedef struct packed {
    logic [CoordBits-1:0] top;
    logic [CoordBits-1:0] left;
    logic [ExtBits-1:0]   h;
    logic [ExtBits-1:0]   w;
    logic [TagBits-1:0]   tag;
  } entry_t;

  // Memory access request from sequencer to table.
  typedef struct packed {
    logic               we;
    logic [IdxBits-1:0] waddr;
    logic [IdxBits-1:0] raddr;
  } mem_req_t;
endpackage

>>> rtl/core/ffrp_table.sv
// Rectangle table memory: one write port, one registered read port.
// Depends on ffrp_pkg.
module ffrp_table import ffrp_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  input  entry_t   wdata,
  output entry_t   rdata
);
  entry_t mem [MaxEntries];

  // Write and read in one clocked block
  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= wdata;
    rdata <= mem[req.raddr];
  end
endmodule

>>> rtl/core/first_fit_rect_packer.sv
// Top level of the first-fit rectangle packer: sequencer plus table memory.
// Depends on ffrp_pkg and ffrp_table.
//
//  channel | direction | signals
//  in      | input     | in_valid, in_stall(out), opcode/width/height/tag
//  out     | output    | out_valid, out_stall(in), status/left/top/bottom/count
//  cfg     | input     | cfg_valid, cfg_ready(out), cfg_index, cfg_data
//
// Sequence: after the accepting edge, a decode state; pack then tries rows and candidate
// spots, reading each table entry (registered read, then compare), and appends;
// remove scans entries for the tag, then shifts the following entries down.
// Every item then sweeps bottom edges over all entries, then presents the output.
// Reset: synchronous, active low; table count clears, atlas is 1024x1024.
// Stalls: in_stall is high from acceptance until the result is taken.
module first_fit_rect_packer import ffrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [ExtBits-1:0]   in_rect_width,
  input  logic [ExtBits-1:0]   in_rect_height,
  input  logic [TagBits-1:0]   in_entry_tag,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [CoordBits-1:0] out_placed_left,
  output logic [CoordBits-1:0] out_placed_top,
  output logic [ExtBits-1:0]   out_max_bottom,
  output logic [CntBits-1:0]   out_entry_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [12:0]          cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ROW, S_SPOT, S_RD, S_CMP, S_RMRD, S_RMCMP,
    S_SHRD, S_SHWR, S_APPEND, S_MBRD, S_MBCMP, S_OUT
  } state_t;

  localparam logic [ExtBits-1:0] Limit = ExtBits'(1 << CoordBits);

  state_t               state_r;
  logic [ExtBits-1:0]   aw_r, ah_r;
  logic                 op_r;
  logic [ExtBits-1:0]   w_r, h_r;
  logic [TagBits-1:0]   tag_r;
  logic [CntBits-1:0]   cnt_r, idx_r;
  logic [ExtBits:0]     x_r, y_r, ny_r;
  logic [2:0]           st_r;
  logic [CoordBits-1:0] pl_r, pt_r;
  logic [ExtBits-1:0]   mb_r;
  mem_req_t             req;
  entry_t               wdata, rdata;
  logic                 cfg_sel;

  ffrp_table u_table (.clk(clk), .req(req), .wdata(wdata), .rdata(rdata));

  assign cfg_ready = 1'b1;
  assign cfg_sel   = cfg_index;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status      = st_r;
  assign out_placed_left = pl_r;
  assign out_placed_top  = pt_r;
  assign out_max_bottom  = mb_r;
  assign out_entry_count = cnt_r;

  // Clamped atlas dimensions
  logic [ExtBits-1:0] awc, ahc;
  assign awc = (aw_r > Limit) ? Limit : aw_r;
  assign ahc = (ah_r > Limit) ? Limit : ah_r;

  // Entry edges from the registered read
  logic [ExtBits:0] e_r, e_b;
  logic             ovl;
  assign e_r = (ExtBits+1)'(rdata.left) + (ExtBits+1)'(rdata.w);
  assign e_b = (ExtBits+1)'(rdata.top) + (ExtBits+1)'(rdata.h);
  assign ovl = !(x_r >= e_r || x_r + (ExtBits+1)'(w_r) <= (ExtBits+1)'(rdata.left) ||
                 y_r >= e_b || y_r + (ExtBits+1)'(h_r) <= (ExtBits+1)'(rdata.top));

  // Memory port drive
  always_comb begin
    req.we    = 1'b0;
    req.waddr = idx_r[IdxBits-1:0];
    req.raddr = idx_r[IdxBits-1:0];
    wdata     = rdata;
    if (state_r == S_SHWR) begin
      req.we    = 1'b1;
      req.waddr = IdxBits'(idx_r - 1'b1);
    end else if (state_r == S_APPEND) begin
      req.we    = 1'b1;
      req.waddr = cnt_r[IdxBits-1:0];
      wdata.top = y_r[CoordBits-1:0];
      wdata.left = x_r[CoordBits-1:0];
      wdata.h   = h_r;
      wdata.w   = w_r;
      wdata.tag = tag_r;
    end
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      aw_r    <= 13'd1024;
      ah_r    <= 13'd1024;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_sel == CfgWidth) aw_r <= cfg_data;
        else ah_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_opcode; w_r <= in_rect_width; h_r <= in_rect_height;
          tag_r <= in_entry_tag; pl_r <= '0; pt_r <= '0; idx_r <= '0;
          state_r <= S_START;
        end
        S_START: begin
          if (op_r == OpRemove) begin
            st_r <= StNotFound;
            state_r <= (cnt_r == 0) ? S_MBRD : S_RMRD;
          end else if (cnt_r == CntBits'(MaxEntries)) begin
            st_r <= StFull; state_r <= S_MBRD;
          end else if (w_r == 0 || h_r == 0) begin
            st_r <= StNoRoom; state_r <= S_MBRD;
          end else begin
            y_r <= '0; state_r <= S_ROW;
          end
        end
        // Start a row if the request still fits vertically
        S_ROW: begin
          if (y_r + (ExtBits+1)'(h_r) <= (ExtBits+1)'(ahc)) begin
            x_r <= '0; ny_r <= (ExtBits+1)'(ahc); state_r <= S_SPOT;
          end else begin
            st_r <= StNoRoom; state_r <= S_MBRD;
          end
        end
        S_SPOT: begin
          idx_r <= '0;
          if (x_r + (ExtBits+1)'(w_r) > (ExtBits+1)'(awc)) begin
            y_r <= ny_r; state_r <= S_ROW;
          end else if (cnt_r == 0) state_r <= S_APPEND;
          else state_r <= S_RD;
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (ovl) begin
            if (e_b < ny_r) ny_r <= e_b;
            x_r <= e_r; state_r <= S_SPOT;
          end else if (idx_r + 1'b1 == cnt_r) state_r <= S_APPEND;
          else begin
            idx_r <= idx_r + 1'b1; state_r <= S_RD;
          end
        end
        S_APPEND: begin
          st_r <= StPlaced; pl_r <= x_r[CoordBits-1:0]; pt_r <= y_r[CoordBits-1:0];
          cnt_r <= cnt_r + 1'b1; idx_r <= '0; mb_r <= '0; state_r <= S_MBRD;
        end
        S_RMRD: state_r <= S_RMCMP;
        S_RMCMP: begin
          if (rdata.tag == tag_r) begin
            st_r <= StRemoved; idx_r <= idx_r + 1'b1; state_r <= S_SHRD;
          end else if (idx_r + 1'b1 == cnt_r) begin
            idx_r <= '0; state_r <= S_MBRD;
          end else begin
            idx_r <= idx_r + 1'b1; state_r <= S_RMRD;
          end
        end
        // Shift following entries down by one
        S_SHRD: begin
          if (idx_r == cnt_r) begin
            cnt_r <= cnt_r - 1'b1; idx_r <= '0; state_r <= S_MBRD;
          end else state_r <= S_SHWR;
        end
        S_SHWR: begin
          idx_r <= idx_r + 1'b1; state_r <= S_SHRD;
        end
        // Sweep for the largest bottom edge
        S_MBRD: begin
          if (idx_r == 0) mb_r <= '0;
          if (idx_r == cnt_r) state_r <= S_OUT;
          else state_r <= S_MBCMP;
        end
        S_MBCMP: begin
          if (e_b[ExtBits-1:0] > mb_r) mb_r <= e_b[ExtBits-1:0];
          idx_r <= idx_r + 1'b1; state_r <= S_MBRD;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntBits'(MaxEntries)) else $error("entry count over capacity");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");
  a_place: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != StPlaced |-> out_placed_left == 0 && out_placed_top == 0)
    else $error("coordinates on failed result");
`endif
endmodule
